### sv/jfd_pkg.sv
`timescale 1ns / 1ps

package jfd_pkg;

	localparam logic [7:0] HDR_FIRST   = 8'h55;
	localparam logic [7:0] HDR_SECOND  = 8'hAA;
	localparam logic [7:0] CRC_POLY    = 8'h8C;
	localparam int         FIELD_DEPTH = 13;
	localparam int         FIELD_AW    = $clog2(FIELD_DEPTH);

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_CRC    = 2'd1;
	localparam logic [1:0] STAT_LEN    = 2'd2;

	typedef logic [FIELD_DEPTH-1:0][7:0] field_t;

	// one finished frame: its status and the captured leading payload bytes
	typedef struct packed {
		logic [1:0] status;
		field_t     bytes;
	} evt_t;

	// reflected CRC-8, one byte folded in eight bit steps
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int n = 0; n < 8; n++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### sv/joint_frame_deframer_crc8.sv
`timescale 1ns / 1ps

// Byte-serial deframer for 0x55 0xAA framed joint commands with a reflected
// CRC-8 (poly 0x8C, init 0) over header, length and payload. One byte is
// taken per cycle while full is low; full rises only when the two-entry
// queue of frame results between the parser and the output register is
// full, which happens only while the result side holds pop low. Each frame
// yields one result (status ok, CRC mismatch or bad length) that goes via
// the queue to the output register. Lengths outside 13..MAX_PAYLOAD are
// reported when the length byte arrives; error results carry zeros.
module joint_frame_deframer_crc8 import jfd_pkg::*; #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         frame_status,
	output logic signed [15:0] joint_one,
	output logic signed [15:0] joint_two,
	output logic signed [15:0] joint_three,
	output logic signed [15:0] joint_four,
	output logic signed [15:0] joint_five,
	output logic signed [15:0] joint_six,
	output logic [7:0]         gripper
);

	logic accept;
	logic evt_push;
	evt_t evt_data;
	logic evq_full;
	logic evq_empty;
	logic evq_pop;
	evt_t evq_data;

	assign full   = evq_full;
	assign accept = push && !evq_full;

	jfd_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.evt_push (evt_push),
		.evt_data (evt_data)
	);

	jfd_evq u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (evt_push),
		.wr_data (evt_data),
		.full    (evq_full),
		.rd_en   (evq_pop),
		.empty   (evq_empty),
		.rd_data (evq_data)
	);

	jfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.evq_empty    (evq_empty),
		.evq_data     (evq_data),
		.evq_pop      (evq_pop),
		.pop          (pop),
		.empty        (empty),
		.frame_status (frame_status),
		.joint_one    (joint_one),
		.joint_two    (joint_two),
		.joint_three  (joint_three),
		.joint_four   (joint_four),
		.joint_five   (joint_five),
		.joint_six    (joint_six),
		.gripper      (gripper)
	);

endmodule

### sv/jfd_front.sv
`timescale 1ns / 1ps

module jfd_front import jfd_pkg::*; #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output logic       evt_push,
	output evt_t       evt_data
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HDR2,
		PH_LEN,
		PH_PAYLOAD,
		PH_CRC
	} phase_t;

	localparam logic [7:0] MAX_LEN  = 8'(MAX_PAYLOAD);
	localparam logic [7:0] MIN_LEN  = 8'(FIELD_DEPTH);
	localparam logic [7:0] HDR_CRC0 = crc8_feed(8'h00, HDR_FIRST);

	phase_t     phase_q;
	logic [7:0] len_q;
	logic [7:0] cnt_q;
	logic [7:0] crc_q;
	field_t     field_q;

	logic       bad_len;
	logic [7:0] cnt_next;
	logic [7:0] crc_next;

	assign bad_len  = (rx_byte < MIN_LEN) || (rx_byte > MAX_LEN);
	assign cnt_next = cnt_q + 8'd1;
	assign crc_next = crc8_feed(crc_q, rx_byte);

	always_comb begin
		evt_push        = 1'b0;
		evt_data.status = STAT_OK;
		evt_data.bytes  = field_q;
		if (accept) begin
			unique case (phase_q)
				PH_LEN: begin
					evt_push        = bad_len;
					evt_data.status = STAT_LEN;
				end
				PH_CRC: begin
					evt_push        = 1'b1;
					evt_data.status = (rx_byte == crc_q) ? STAT_OK : STAT_CRC;
				end
				default: begin
					evt_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			cnt_q   <= '0;
			crc_q   <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HDR2: begin
					if (rx_byte == HDR_SECOND) begin
						crc_q   <= crc8_feed(HDR_CRC0, rx_byte);
						phase_q <= PH_LEN;
					end else if (rx_byte != HDR_FIRST) begin
						phase_q <= PH_HUNT;
					end
				end
				PH_LEN: begin
					if (bad_len) begin
						phase_q <= PH_HUNT;
						len_q   <= '0;
						cnt_q   <= '0;
						crc_q   <= '0;
					end else begin
						len_q   <= rx_byte;
						cnt_q   <= '0;
						crc_q   <= crc_next;
						phase_q <= PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					crc_q <= crc_next;
					cnt_q <= cnt_next;
					if (cnt_next >= len_q) begin
						phase_q <= PH_CRC;
					end
				end
				PH_CRC: begin
					phase_q <= PH_HUNT;
					len_q   <= '0;
					cnt_q   <= '0;
					crc_q   <= '0;
				end
				default: begin
					phase_q <= (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
				end
			endcase
		end
	end

	// capture only the leading payload bytes; the rest feed the CRC alone
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_PAYLOAD && cnt_q < MIN_LEN) begin
			field_q[cnt_q[FIELD_AW-1:0]] <= rx_byte;
		end
	end

endmodule

### sv/jfd_evq.sv
`timescale 1ns / 1ps

module jfd_evq import jfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  evt_t wr_data,
	output logic full,
	input  logic rd_en,
	output logic empty,
	output evt_t rd_data
);

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);

	evt_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;

	logic do_wr;
	logic do_rd;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### sv/jfd_back.sv
`timescale 1ns / 1ps

module jfd_back import jfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               evq_empty,
	input  evt_t               evq_data,
	output logic               evq_pop,
	input  logic               pop,
	output logic               empty,
	output logic [1:0]         frame_status,
	output logic signed [15:0] joint_one,
	output logic signed [15:0] joint_two,
	output logic signed [15:0] joint_three,
	output logic signed [15:0] joint_four,
	output logic signed [15:0] joint_five,
	output logic signed [15:0] joint_six,
	output logic [7:0]         gripper
);

	logic        valid_q;
	logic [1:0]  status_q;
	logic [15:0] j1_q, j2_q, j3_q, j4_q, j5_q, j6_q;
	logic [7:0]  grip_q;

	logic        ok;
	logic [15:0] raw2;
	logic [15:0] neg2;

	// load a new result when the output slot is free or being drained
	assign evq_pop = !evq_empty && (!valid_q || pop);
	assign ok      = (evq_data.status == STAT_OK);
	assign raw2    = {evq_data.bytes[3], evq_data.bytes[2]};
	assign neg2    = (raw2 == 16'h8000) ? 16'h7FFF : (16'h0000 - raw2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (evq_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evq_pop) begin
			status_q <= evq_data.status;
			j1_q     <= ok ? {evq_data.bytes[1],  evq_data.bytes[0]}  : '0;
			j2_q     <= ok ? neg2 : '0;
			j3_q     <= ok ? {evq_data.bytes[5],  evq_data.bytes[4]}  : '0;
			j4_q     <= ok ? {evq_data.bytes[7],  evq_data.bytes[6]}  : '0;
			j5_q     <= ok ? {evq_data.bytes[9],  evq_data.bytes[8]}  : '0;
			j6_q     <= ok ? {evq_data.bytes[11], evq_data.bytes[10]} : '0;
			grip_q   <= ok ? evq_data.bytes[12] : '0;
		end
	end

	assign empty        = !valid_q;
	assign frame_status = status_q;
	assign joint_one    = signed'(j1_q);
	assign joint_two    = signed'(j2_q);
	assign joint_three  = signed'(j3_q);
	assign joint_four   = signed'(j4_q);
	assign joint_five   = signed'(j5_q);
	assign joint_six    = signed'(j6_q);
	assign gripper      = grip_q;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top import jfd_pkg::*;;

	localparam int     MAX_PAYLOAD  = 32;
	localparam int     DRAIN_CYCLES = 20;
	localparam int     HOLD_CYCLES  = 800;
	localparam longint CYCLE_LIMIT  = 200000;
	localparam logic [7:0] TRAILER_CR = 8'h0D;
	localparam logic [7:0] TRAILER_LF = 8'h0A;

	typedef enum logic [2:0] {PH_HUNT, PH_SYNC, PH_LEN, PH_BODY, PH_CRC} hunt_phase_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [5:0][15:0] joints;
		logic [7:0]       grip;
	} frame_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         rx_byte;
	logic               empty;
	logic               pop;
	logic [1:0]         frame_status;
	logic signed [15:0] joint_one;
	logic signed [15:0] joint_two;
	logic signed [15:0] joint_three;
	logic signed [15:0] joint_four;
	logic signed [15:0] joint_five;
	logic signed [15:0] joint_six;
	logic [7:0]         gripper;

	joint_frame_deframer_crc8 #(.MAX_PAYLOAD(MAX_PAYLOAD)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.frame_status(frame_status),
		.joint_one(joint_one),
		.joint_two(joint_two),
		.joint_three(joint_three),
		.joint_four(joint_four),
		.joint_five(joint_five),
		.joint_six(joint_six),
		.gripper(gripper)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// byte stream to send and frames the deframer owes us
	logic [7:0]    line_bytes[$];
	frame_result_t pending_frames[$];
	logic [7:0]    body[MAX_PAYLOAD];

	// deframer state as we track it
	hunt_phase_t rx_phase   = PH_HUNT;
	logic [7:0]  body_len   = 8'h00;
	logic [7:0]  body_count = 8'h00;
	logic [7:0]  frame_crc  = 8'h00;
	logic [7:0]  captured[FIELD_DEPTH];

	int     frames_planned = 0;
	int     total_bytes = 0;
	int     bytes_sent = 0;
	int     results_seen = 0;
	int     ok_seen = 0;
	int     crc_seen = 0;
	int     len_seen = 0;
	int     error_count = 0;
	int     full_stalls = 0;
	int     holds_done = 0;
	int     hold_left = 0;
	int     send_wait = 0;
	int     take_wait = 0;
	bit     send_calm = 1'b0;
	bit     take_calm = 1'b0;
	longint cycles = 0;

	// reflected CRC-8, one message bit per step
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ ((c[0] ^ b[i]) ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic int idle_draw(input bit calm);
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	task automatic restart_hunt();
		rx_phase   = PH_HUNT;
		body_len   = 8'h00;
		body_count = 8'h00;
		frame_crc  = 8'h00;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		frame_result_t r;
		logic [15:0]   raw;
		r = '0;
		case (rx_phase)
			PH_SYNC: begin
				if (b == HDR_SECOND) begin
					frame_crc = crc8_step(crc8_step(8'h00, HDR_FIRST), b);
					rx_phase  = PH_LEN;
				end else if (b != HDR_FIRST) begin
					rx_phase = PH_HUNT;
				end
			end
			PH_LEN: begin
				if (b < FIELD_DEPTH || b > MAX_PAYLOAD) begin
					restart_hunt();
					r.status = STAT_LEN;
					pending_frames.push_back(r);
				end else begin
					body_len   = b;
					body_count = 8'h00;
					frame_crc  = crc8_step(frame_crc, b);
					rx_phase   = PH_BODY;
				end
			end
			PH_BODY: begin
				// bytes past the thirteenth only feed the CRC
				if (body_count < FIELD_DEPTH) begin
					captured[body_count[FIELD_AW-1:0]] = b;
				end
				frame_crc  = crc8_step(frame_crc, b);
				body_count = body_count + 8'd1;
				if (body_count >= body_len) begin
					rx_phase = PH_CRC;
				end
			end
			PH_CRC: begin
				if (b == frame_crc) begin
					r.status = STAT_OK;
					for (int j = 0; j < 6; j++) begin
						raw = {captured[2 * j + 1], captured[2 * j]};
						// joint two is negated; the most negative value clips
						if (j == 1) begin
							raw = (raw == 16'h8000) ? 16'h7FFF : -raw;
						end
						r.joints[j] = raw;
					end
					r.grip = captured[12];
				end else begin
					r.status = STAT_CRC;
				end
				pending_frames.push_back(r);
				restart_hunt();
			end
			default: begin
				rx_phase = (b == HDR_FIRST) ? PH_SYNC : PH_HUNT;
			end
		endcase
	endtask

	task automatic put_frame(input int len, input bit spoil, input bit with_trailer);
		logic [7:0] c;
		c = crc8_step(crc8_step(crc8_step(8'h00, HDR_FIRST), HDR_SECOND), len[7:0]);
		line_bytes.push_back(HDR_FIRST);
		line_bytes.push_back(HDR_SECOND);
		line_bytes.push_back(len[7:0]);
		for (int k = 0; k < len; k++) begin
			line_bytes.push_back(body[k]);
			c = crc8_step(c, body[k]);
		end
		if (spoil) begin
			c = c ^ (8'h01 << $urandom_range(0, 7));
		end
		line_bytes.push_back(c);
		if (with_trailer) begin
			line_bytes.push_back(TRAILER_CR);
			line_bytes.push_back(TRAILER_LF);
		end
		frames_planned++;
	endtask

	task automatic fill_body(input int len);
		for (int k = 0; k < len; k++) begin
			body[k] = $urandom_range(0, 255);
		end
		// pull joints toward the edges of the 16-bit range
		for (int j = 0; j < 6; j++) begin
			case ($urandom_range(0, 7))
				0: {body[2 * j + 1], body[2 * j]} = 16'h8000;
				1: {body[2 * j + 1], body[2 * j]} = 16'h7FFF;
				2: {body[2 * j + 1], body[2 * j]} = 16'h0000;
				3: {body[2 * j + 1], body[2 * j]} = 16'hFFFF;
				default: ;
			endcase
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		error_count++;
		if (error_count <= 10) begin
			$display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
		end
	endtask

	task automatic check_frame();
		frame_result_t want;
		frame_result_t got;
		got.status = frame_status;
		got.joints = {joint_six, joint_five, joint_four, joint_three, joint_two, joint_one};
		got.grip   = gripper;
		if (pending_frames.size() == 0) begin
			flag_mismatch("unexpected result, status", 16'h0000, {14'd0, got.status});
			return;
		end
		want = pending_frames.pop_front();
		case (want.status)
			STAT_OK:  ok_seen++;
			STAT_CRC: crc_seen++;
			default:  len_seen++;
		endcase
		if (got.status !== want.status) begin
			flag_mismatch("frame_status", {14'd0, want.status}, {14'd0, got.status});
		end
		for (int j = 0; j < 6; j++) begin
			if (got.joints[j] !== want.joints[j]) begin
				flag_mismatch($sformatf("joint %0d", j + 1), want.joints[j], got.joints[j]);
			end
		end
		if (got.grip !== want.grip) begin
			flag_mismatch("gripper", {8'd0, want.grip}, {8'd0, got.grip});
		end
	endtask

	// sender: offer the next byte, hold it while full
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push      <= 1'b0;
			rx_byte   <= 8'h00;
			send_wait <= 0;
		end else begin
			if (push && !full) begin
				deframe_byte(rx_byte);
				bytes_sent++;
				if ($urandom_range(0, 39) == 0) begin
					send_calm <= ~send_calm;
				end
			end
			if (push && full) begin
				full_stalls++;
			end else if (send_wait != 0) begin
				push      <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (line_bytes.size() != 0) begin
				push      <= 1'b1;
				rx_byte   <= line_bytes.pop_front();
				send_wait <= idle_draw(send_calm);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: check each transfer, then idle or stall
	always @(posedge clk or negedge arst_n) begin : take_side
		int gap;
		if (!arst_n) begin
			pop       <= 1'b0;
			take_wait <= 0;
		end else begin
			gap = take_wait;
			if (pop && !empty) begin
				check_frame();
				results_seen++;
				gap = idle_draw(take_calm);
				if ($urandom_range(0, 15) == 0) begin
					take_calm <= ~take_calm;
				end
			end
			if (hold_left != 0) begin
				pop       <= 1'b0;
				take_wait <= gap;
			end else if (gap != 0) begin
				pop       <= 1'b0;
				take_wait <= gap - 1;
			end else begin
				pop       <= 1'b1;
				take_wait <= 0;
			end
		end
	end

	// long receiver stalls so the result queue fills and full rises
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && results_seen == 4) ||
				(holds_done == 1 && results_seen == 30)) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		int len;
		int n;
		arst_n = 1'b0;

		// directed: other byte after 0x55, both bad-length edges, repeated 0x55, then two good frames and one bad CRC
		line_bytes.push_back(HDR_FIRST);
		line_bytes.push_back(8'h12);
		line_bytes.push_back(HDR_FIRST);
		line_bytes.push_back(HDR_SECOND);
		line_bytes.push_back(8'(FIELD_DEPTH - 1));
		line_bytes.push_back(HDR_FIRST);
		line_bytes.push_back(HDR_FIRST);
		line_bytes.push_back(HDR_SECOND);
		line_bytes.push_back(8'(MAX_PAYLOAD + 1));
		frames_planned += 2;
		line_bytes.push_back(HDR_FIRST);
		{body[1], body[0]}   = 16'h7FFF;
		{body[3], body[2]}   = 16'h8000;
		{body[5], body[4]}   = 16'h0000;
		{body[7], body[6]}   = 16'hFFFF;
		{body[9], body[8]}   = 16'h0001;
		{body[11], body[10]} = 16'h8000;
		body[12] = 8'hFF;
		put_frame(FIELD_DEPTH, 1'b0, 1'b0);
		{body[1], body[0]}   = 16'h8000;
		{body[3], body[2]}   = 16'h0000;
		{body[5], body[4]}   = 16'h7FFF;
		{body[7], body[6]}   = 16'h0000;
		{body[9], body[8]}   = 16'hFFFF;
		{body[11], body[10]} = 16'h7FFF;
		body[12] = 8'h00;
		put_frame(FIELD_DEPTH, 1'b0, 1'b0);
		put_frame(FIELD_DEPTH, 1'b1, 1'b0);

		// random: mostly well-formed frames, some corrupt, some noise
		while (line_bytes.size() < 1000 || frames_planned < 60) begin
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					case ($urandom_range(0, 3))
						0: len = 0;
						1: len = 255;
						2: len = $urandom_range(0, FIELD_DEPTH - 1);
						default: len = $urandom_range(MAX_PAYLOAD + 1, 255);
					endcase
					line_bytes.push_back(HDR_FIRST);
					line_bytes.push_back(HDR_SECOND);
					line_bytes.push_back(len[7:0]);
					frames_planned++;
				end
				3, 4: begin
					n = $urandom_range(1, 6);
					for (int k = 0; k < n; k++) begin
						case ($urandom_range(0, 3))
							0: line_bytes.push_back(HDR_FIRST);
							1: line_bytes.push_back(HDR_SECOND);
							default: line_bytes.push_back(8'($urandom_range(0, 255)));
						endcase
					end
				end
				5: begin
					// cut a frame short; the bytes that follow land in its payload
					len = $urandom_range(FIELD_DEPTH, MAX_PAYLOAD);
					line_bytes.push_back(HDR_FIRST);
					line_bytes.push_back(HDR_SECOND);
					line_bytes.push_back(len[7:0]);
					n = $urandom_range(1, len - 1);
					for (int k = 0; k < n; k++) begin
						line_bytes.push_back(8'($urandom_range(0, 255)));
					end
				end
				default: begin
					case ($urandom_range(0, 3))
						0: len = FIELD_DEPTH;
						1: len = MAX_PAYLOAD;
						default: len = $urandom_range(FIELD_DEPTH + 1, MAX_PAYLOAD - 1);
					endcase
					fill_body(len);
					put_frame(len, $urandom_range(0, 5) == 0, $urandom_range(0, 3) != 0);
				end
			endcase
		end
		total_bytes = line_bytes.size();

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (bytes_sent < total_bytes) @(posedge clk);
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_frames.size() != 0) begin
			$display("%0d expected frame results never arrived", pending_frames.size());
			error_count += pending_frames.size();
		end
		$display("Run covered %0d bytes and %0d frame results: %0d good, %0d crc, %0d length",
			bytes_sent, results_seen, ok_seen, crc_seen, len_seen);
		$display("Receiver held off %0d times; sender waited on full for %0d cycles",
			holds_done, full_stalls);
		if (error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
